FILE: sv/dlkl_pkg.sv
// Shared types and constants for the doubly linked key list.
// No dependencies.
package dlkl_pkg;
  localparam int unsigned CapacityDefault = 16;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_WALK,
    S_READ,
    S_NBR_P,
    S_NBR_N,
    S_UNLINK_P,
    S_UNLINK_N,
    S_DONE,
    S_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the request word
    logic scan_start; // clear the free-slot scan, or start walk at head
    logic scan_step;  // advance the scan by one slot
    logic do_insert;  // write the new slot and relink head
    logic rd_cur;     // read current slot
    logic walk_step;  // advance to next
    logic rd_prev;    // read previous neighbour key
    logic rd_next;    // read next neighbour key
    logic fix_prev;   // rewrite prev.next or head
    logic fix_next;   // rewrite next.prev and free slot
    logic set_miss;
    logic set_full;
    logic set_hit;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    func_t func;
    logic  scan_found;
    logic  scan_end;
    logic  cur_nil;
    logic  walk_end;
    logic  match;
    logic  prev_nil;
    logic  next_nil;
  } sts_t;
endpackage

FILE: sv/doubly_linked_key_list_top.sv
// Doubly linked list of signed 32-bit keys in a pool of CAPACITY slots.
// One request (func, key) gives one result. Insert scans the free map one
// slot a cycle and takes the lowest free slot; search and delete walk the
// list from the head one linked slot a cycle through the slot memories.
// One request is in work at a time; the result register lets the next
// request start while the last result waits to be taken.
module doubly_linked_key_list_top #(
  parameter int unsigned CAPACITY = dlkl_pkg::CapacityDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic signed [31:0] key,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic               has_prev,
  output logic signed [31:0] prev_key,
  output logic               has_next,
  output logic signed [31:0] next_key
);
  import dlkl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dlkl_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts, .cmd
  );

  dlkl_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .rst, .cmd, .sts, .func, .key,
    .status, .has_prev, .prev_key, .has_next, .next_key
  );
endmodule

FILE: sv/dlkl_ctrl.sv
// Controller state machine for the doubly linked key list.
// Depends on dlkl_pkg.
module dlkl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  dlkl_pkg::sts_t sts,
  output dlkl_pkg::cmd_t cmd
);
  import dlkl_pkg::*;

  state_t state, state_next;
  logic   out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  assign out_valid = out_full;

  always_comb begin
    out_full_next = out_full;
    if (out_full && out_ready) out_full_next = 1'b0;
    if (cmd.out_load) out_full_next = 1'b1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_ALLOC;
      end
      S_ALLOC: begin
        unique case (sts.func)
          FUNC_INSERT: state_next = S_WALK;
          FUNC_SEARCH, FUNC_DELETE: state_next = S_READ;
          default: state_next = S_DONE;
        endcase
      end
      S_WALK: begin
        // free-slot scan
        if (sts.scan_found || sts.scan_end) state_next = S_DONE;
      end
      S_READ: begin
        if (sts.cur_nil || sts.walk_end) state_next = S_DONE;
        else if (sts.match)
          state_next = (sts.func == FUNC_SEARCH) ? S_NBR_P : S_UNLINK_P;
      end
      S_NBR_P:    state_next = S_NBR_N;
      S_NBR_N:    state_next = S_DONE;
      S_UNLINK_P: state_next = S_UNLINK_N;
      S_UNLINK_N: state_next = S_DONE;
      S_DONE: begin
        if (!out_full) state_next = S_OUT;
      end
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.load   = in_valid;
      end
      S_ALLOC: begin
        cmd.scan_start = 1'b1;
      end
      S_WALK: begin
        if (sts.scan_found) cmd.do_insert = 1'b1;
        else if (sts.scan_end) cmd.set_full = 1'b1;
        else cmd.scan_step = 1'b1;
      end
      S_READ: begin
        if (sts.cur_nil || sts.walk_end) cmd.set_miss = 1'b1;
        else if (sts.match) cmd.set_hit = 1'b1;
        else cmd.walk_step = 1'b1;
      end
      S_NBR_P:    cmd.rd_prev  = 1'b1;
      S_NBR_N:    cmd.rd_next  = 1'b1;
      S_UNLINK_P: cmd.fix_prev = 1'b1;
      S_UNLINK_N: cmd.fix_next = 1'b1;
      S_DONE:     cmd.out_load = !out_full;
      S_OUT:      ;
      default:    ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_ready && in_valid) |=> !in_ready) else $error("item taken while busy");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_full) else $error("result overwritten");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
`endif
endmodule

FILE: sv/dlkl_dp.sv
// Datapath for the doubly linked key list: slot memories, free map, head,
// walk pointer and result register. Depends on dlkl_pkg.
module dlkl_dp #(
  parameter int unsigned CAPACITY = dlkl_pkg::CapacityDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dlkl_pkg::cmd_t        cmd,
  output dlkl_pkg::sts_t        sts,
  input  logic [1:0]            func,
  input  logic signed [31:0]    key,
  output logic [1:0]            status,
  output logic                  has_prev,
  output logic signed [31:0]    prev_key,
  output logic                  has_next,
  output logic signed [31:0]    next_key
);
  import dlkl_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  logic [31:0]   mem_key  [CAPACITY];
  logic [LW-1:0] mem_next [CAPACITY];
  logic [LW-1:0] mem_prev [CAPACITY];

  logic [CAPACITY-1:0] free_map;
  logic [LW-1:0]       head;
  func_t               req_func;
  logic [31:0]         req_key;
  logic [LW-1:0]       cur;   // walk pointer or scan index
  logic [LW-1:0]       steps;
  logic [LW-1:0]       hit_prev, hit_next;
  status_t             res_status;
  logic                res_hp, res_hn;
  logic [31:0]         res_pk, res_nk;

  logic [IW-1:0] cur_i;
  assign cur_i = cur[IW-1:0];

  assign sts.func       = req_func;
  assign sts.scan_found = (cur != NIL) && free_map[cur_i];
  assign sts.scan_end   = (cur == NIL);
  assign sts.cur_nil    = (cur == NIL);
  assign sts.walk_end   = (steps == NIL);
  assign sts.match      = (cur != NIL) && (mem_key[cur_i] == req_key);
  assign sts.prev_nil   = (hit_prev == NIL);
  assign sts.next_nil   = (hit_next == NIL);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func <= func_t'(func);
      req_key  <= key;
    end
    if (cmd.scan_start) begin
      cur   <= (func_t'(req_func) == FUNC_INSERT) ? '0 : head;
      steps <= '0;
    end else if (cmd.scan_step) begin
      cur <= cur + 1'b1;
    end else if (cmd.walk_step) begin
      cur   <= mem_next[cur_i];
      steps <= steps + 1'b1;
    end
    if (cmd.load) begin
      res_status <= ST_OK;
      res_hp <= 1'b0;
      res_hn <= 1'b0;
      res_pk <= '0;
      res_nk <= '0;
    end
    if (cmd.set_full) res_status <= ST_FULL;
    if (cmd.set_miss) res_status <= ST_NOTFOUND;
    if (cmd.set_hit) begin
      hit_prev <= mem_prev[cur_i];
      hit_next <= mem_next[cur_i];
    end
    if (cmd.rd_prev && !sts.prev_nil) begin
      res_hp <= 1'b1;
      res_pk <= mem_key[hit_prev[IW-1:0]];
    end
    if (cmd.rd_next && !sts.next_nil) begin
      res_hn <= 1'b1;
      res_nk <= mem_key[hit_next[IW-1:0]];
    end
    if (cmd.do_insert) begin
      mem_key[cur_i]  <= req_key;
      mem_next[cur_i] <= head;
      mem_prev[cur_i] <= NIL;
      if (head != NIL) mem_prev[head[IW-1:0]] <= cur;
    end
    if (cmd.fix_prev && !sts.prev_nil) mem_next[hit_prev[IW-1:0]] <= hit_next;
    if (cmd.fix_next && !sts.next_nil) mem_prev[hit_next[IW-1:0]] <= hit_prev;
    if (cmd.out_load) begin
      status   <= res_status;
      has_prev <= res_hp;
      prev_key <= res_pk;
      has_next <= res_hn;
      next_key <= res_nk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
      head     <= NIL;
    end else begin
      if (cmd.do_insert) begin
        free_map[cur_i] <= 1'b0;
        head <= cur;
      end
      if (cmd.fix_prev && sts.prev_nil) head <= hit_next;
      if (cmd.fix_next) free_map[cur_i] <= 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= NIL) else $error("head out of range");
  a_ins_free: assert property (@(posedge clk) disable iff (rst)
    cmd.do_insert |-> free_map[cur_i]) else $error("insert into used slot");
  a_del_used: assert property (@(posedge clk) disable iff (rst)
    cmd.fix_next |-> !free_map[cur_i]) else $error("freeing a free slot");
`endif
endmodule
